@@ rtl/sha1sh_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 stream hasher.
// No dependencies; imported by the controller, datapath and top level.
package sha1sh_pkg;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned NumWords  = 5;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] HInit [NumWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [7:0] ZeroByte = 8'h00;

  localparam logic [5:0] LastSlot   = 6'd63;
  localparam logic [5:0] LengthSlot = 6'd56;
  localparam logic [6:0] LastRound  = 7'd79;
  localparam logic [2:0] LastIndex  = 3'd4;

  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_PAD,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_e;

  typedef struct packed {
    logic       push;       // shift one byte into the block buffer
    byte_sel_e  byte_sel;   // source of the pushed byte
    logic       load_work;  // copy chain words into a..e
    logic       round;      // run one compression round
    logic [6:0] round_idx;  // round number, 0 to 79
    logic       add_chain;  // fold a..e into the chain words
    logic       out_shift;  // rotate the chain words toward the output
    logic       clear;      // restore initial chain and zero length
  } dp_cmd_t;

  function automatic logic [31:0] round_f(input logic [6:0] idx, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    if (idx < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (idx < 7'd40) begin
      res = b ^ c ^ d;
    end else if (idx < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] idx);
    logic [31:0] res;
    if (idx < 7'd20) begin
      res = K0;
    end else if (idx < 7'd40) begin
      res = K1;
    end else if (idx < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

@@ rtl/sha1sh_ctrl.sv @@
// Controller of the SHA-1 stream hasher: handshakes, fill count, padding
// sequence, round counter and digest output. Depends on sha1sh_pkg.
module sha1sh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic                present_i,
  input  logic                end_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output logic [2:0]          m_index_o,
  output logic                m_last_o,
  output sha1sh_pkg::dp_cmd_t cmd_o
);
  import sha1sh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_e;

  state_e     state_q;
  logic [5:0] fill_q;
  logic       fin_q;
  logic       sent80_q;
  logic [3:0] len_cnt_q;
  logic [6:0] round_q;
  logic [2:0] idx_q;
  logic       m_valid_q;

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;
  assign m_index_o = idx_q;
  assign m_last_o  = (idx_q == LastIndex);

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.push     = s_valid_i & present_i;
        cmd_o.byte_sel = BYTE_DATA;
      end
      ST_PAD: begin
        cmd_o.push = 1'b1;
        if (!sent80_q) begin
          cmd_o.byte_sel = BYTE_PAD;
        end else if (len_cnt_q == 4'd0 && fill_q != LengthSlot) begin
          cmd_o.byte_sel = BYTE_ZERO;
        end else begin
          cmd_o.byte_sel = BYTE_LEN;
        end
      end
      ST_COMP: begin
        cmd_o.round     = 1'b1;
        cmd_o.round_idx = round_q;
      end
      ST_ADD: begin
        cmd_o.add_chain = 1'b1;
      end
      ST_OUT: begin
        cmd_o.out_shift = m_ready_i;
        cmd_o.clear     = m_ready_i & (idx_q == LastIndex);
      end
      default: begin
        cmd_o = '0;
      end
    endcase
    cmd_o.load_work = cmd_o.push & (fill_q == LastSlot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      fin_q     <= 1'b0;
      sent80_q  <= 1'b0;
      len_cnt_q <= '0;
      round_q   <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_valid_i) begin
            if (present_i) begin
              fill_q <= fill_q + 6'd1;
              if (fill_q == LastSlot) begin
                state_q <= ST_COMP;
                round_q <= '0;
                fin_q   <= end_i;
              end else if (end_i) begin
                state_q <= ST_PAD;
                fin_q   <= 1'b1;
              end
            end else if (end_i) begin
              state_q <= ST_PAD;
              fin_q   <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          fill_q <= fill_q + 6'd1;
          if (!sent80_q) begin
            sent80_q <= 1'b1;
          end else if (len_cnt_q != 4'd0 || fill_q == LengthSlot) begin
            len_cnt_q <= len_cnt_q + 4'd1;
          end
          if (fill_q == LastSlot) begin
            state_q <= ST_COMP;
            round_q <= '0;
          end
        end
        ST_COMP: begin
          round_q <= round_q + 7'd1;
          if (round_q == LastRound) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (!fin_q) begin
            state_q <= ST_IDLE;
          end else if (len_cnt_q[3]) begin
            state_q   <= ST_OUT;
            idx_q     <= '0;
            m_valid_q <= 1'b1;
          end else begin
            state_q <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (m_ready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == LastIndex) begin
              state_q   <= ST_IDLE;
              m_valid_q <= 1'b0;
              fin_q     <= 1'b0;
              sent80_q  <= 1'b0;
              len_cnt_q <= '0;
              fill_q    <= '0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/sha1sh_dp.sv @@
// Datapath of the SHA-1 stream hasher: block buffer / message schedule,
// round registers, chain words and bit length. Depends on sha1sh_pkg.
module sha1sh_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha1sh_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]          data_i,
  output logic [31:0]         digest_o
);
  import sha1sh_pkg::*;

  // Word j of the window sits at msg_q[511-32*j -: 32]; word 0 is oldest.
  logic [511:0] msg_q;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  ch_q [NumWords];
  logic [63:0]  len_q;

  logic [7:0]  push_byte;
  logic [31:0] w0, w2, w8, w13, wx, w_next, t_sum;

  always_comb begin
    case (cmd_i.byte_sel)
      BYTE_DATA: push_byte = data_i;
      BYTE_PAD:  push_byte = PadByte;
      BYTE_ZERO: push_byte = ZeroByte;
      BYTE_LEN:  push_byte = len_q[63:56];
      default:   push_byte = ZeroByte;
    endcase
  end

  assign w0     = msg_q[511:480];
  assign w2     = msg_q[447:416];
  assign w8     = msg_q[255:224];
  assign w13    = msg_q[95:64];
  assign wx     = w13 ^ w8 ^ w2 ^ w0;
  assign w_next = {wx[30:0], wx[31]};
  assign t_sum  = {a_q[26:0], a_q[31:27]} + round_f(cmd_i.round_idx, b_q, c_q, d_q)
                + e_q + w0 + round_k(cmd_i.round_idx);

  assign digest_o = ch_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      msg_q <= {msg_q[503:0], push_byte};
    end else if (cmd_i.round) begin
      msg_q <= {msg_q[479:0], w_next};
    end
    if (cmd_i.load_work) begin
      a_q <= ch_q[0];
      b_q <= ch_q[1];
      c_q <= ch_q[2];
      d_q <= ch_q[3];
      e_q <= ch_q[4];
    end else if (cmd_i.round) begin
      a_q <= t_sum;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      for (int i = 0; i < NumWords; i++) begin
        ch_q[i] <= HInit[i];
      end
    end else begin
      if (cmd_i.clear) begin
        len_q <= '0;
        for (int i = 0; i < NumWords; i++) begin
          ch_q[i] <= HInit[i];
        end
      end else begin
        if (cmd_i.push && cmd_i.byte_sel == BYTE_DATA) begin
          len_q <= len_q + 64'd8;
        end else if (cmd_i.push && cmd_i.byte_sel == BYTE_LEN) begin
          len_q <= {len_q[55:0], 8'h00};
        end
        if (cmd_i.add_chain) begin
          ch_q[0] <= ch_q[0] + a_q;
          ch_q[1] <= ch_q[1] + b_q;
          ch_q[2] <= ch_q[2] + c_q;
          ch_q[3] <= ch_q[3] + d_q;
          ch_q[4] <= ch_q[4] + e_q;
        end else if (cmd_i.out_shift) begin
          for (int i = 0; i < NumWords - 1; i++) begin
            ch_q[i] <= ch_q[i + 1];
          end
          ch_q[NumWords - 1] <= ch_q[0];
        end
      end
    end
  end

endmodule

@@ rtl/sha1_stream_hasher_core.sv @@
// Top level of the SHA-1 stream hasher: joins the controller and datapath.
// Depends on sha1sh_pkg, sha1sh_ctrl and sha1sh_dp.
//
// SHA-1 over a byte stream. Each input transfer may carry one message byte
// (tuser high) and may close the message (tlast high). While idle the block
// takes one transfer per cycle. The transfer that fills a 64-byte block
// holds the input while the single round unit runs the 80 rounds and the
// result is folded into the chain words. A closing transfer starts
// padding, fed one byte per cycle through the same buffer between
// compressions (0x80, zeros up to byte 56, then the 64-bit big-endian bit
// length), with one or two compressions along the way. The digest then
// leaves as five 32-bit transfers, H0 first, index in tuser and tlast on
// the fifth; after the fifth the chain words, bit length and padding state
// are restored and the block accepts the next message. The input stays
// stalled from the closing transfer until the last digest word is taken.
// The bit length wraps modulo 2^64.
module sha1_stream_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,   // end_of_message
  // digest stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);
  import sha1sh_pkg::*;

  // command bundle from the sequencer to the hash datapath
  dp_cmd_t cmd;

  sha1sh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .present_i (s_axis_tuser),
    .end_i     (s_axis_tlast),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_index_o (m_axis_tuser),
    .m_last_o  (m_axis_tlast),
    .cmd_o     (cmd)
  );

  // digest word comes straight from the head chain register
  sha1sh_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .data_i   (s_axis_tdata),
    .digest_o (m_axis_tdata)
  );

endmodule
